// ===== rtl/weo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel encoder odometry package
// Widths, codes and payload types shared by the odometry front end, the
// measurement back end and the top level.
// ----------------------------------------------------------------------------
package weo_pkg;

  // Field and state widths.
  localparam int CNT_W   = 32;
  localparam int TIME_W  = 48;
  localparam int DPP_W   = 32;
  localparam int STALE_W = 24;
  localparam int DIST_W  = 48;
  localparam int SPD_W   = 32;
  localparam int OP_W    = 2;
  localparam int NSIDE   = 2;
  localparam int SIDE_W  = 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DPP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE = 1'd1;
  localparam logic [DPP_W-1:0]     DPP_RESET   = 32'd65536;
  localparam logic [STALE_W-1:0]   STALE_RESET = 24'd1000000;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PULSE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Speed arithmetic: numerator is dist_per_pulse * 1e6 * count difference.
  localparam int USEC_W = 20;
  localparam logic [USEC_W-1:0] US_PER_S = 20'd1000000;
  localparam int KDPP_W = DPP_W + USEC_W;
  localparam int LO_W   = 32;
  localparam int HI_W   = KDPP_W - LO_W;
  localparam int NUM_W  = KDPP_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(SPD_W);

  // Queue sizes.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIDE_W-1:0] side;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_left;
    logic [DIST_W-1:0] dist_right;
    logic [DIST_W-1:0] mean_distance;
    logic [SPD_W-1:0]  speed_left;
    logic [SPD_W-1:0]  speed_right;
    logic [SPD_W-1:0]  mean_speed;
  } out_item_t;

  typedef struct packed {
    logic [DPP_W-1:0]   dist_per_pulse;
    logic [STALE_W-1:0] stale_limit_us;
  } cfg_t;

  // Encoder state of one side after the item's operation.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  prev_count;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] prev_stamp;
  } side_snap_t;

  typedef struct packed {
    side_snap_t [NSIDE-1:0] side;
    logic [TIME_W-1:0]      now_us;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL0,
    B_MUL1,
    B_MUL2,
    B_NUM,
    B_CHK,
    B_DIV,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic job_pop;
    logic res_push;
    logic side_done;
  } back_ctrl_t;

endpackage

// ===== rtl/weo_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry front end
// Accepts items, applies pulse and clear operations to the encoder state and
// queues a snapshot of both sides for the measurement back end.
// ----------------------------------------------------------------------------
module weo_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  weo_pkg::in_item_t in_data,
  output logic              job_avail,
  input  logic              job_pop,
  output weo_pkg::job_t     job_head
);
  import weo_pkg::*;

  logic [CNT_W-1:0]  cnt_r [NSIDE];
  logic [CNT_W-1:0]  pcnt_r [NSIDE];
  logic [TIME_W-1:0] stamp_r [NSIDE];
  logic [TIME_W-1:0] pstamp_r [NSIDE];

  job_t              job_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] job_cnt_r;

  logic accept;
  logic pop_ok;
  job_t snap;

  assign full      = (job_cnt_r == QCNT_W'(QDEPTH));
  assign accept    = push && !full;
  assign job_avail = (job_cnt_r != '0);
  assign pop_ok    = job_pop && job_avail;
  assign job_head  = job_mem_r[rd_ptr_r];

  // State of both sides as it stands after this item's operation.
  always_comb begin
    snap.now_us = in_data.now_us;
    for (int s = 0; s < NSIDE; s++) begin
      snap.side[s].count      = cnt_r[s];
      snap.side[s].prev_count = pcnt_r[s];
      snap.side[s].stamp      = stamp_r[s];
      snap.side[s].prev_stamp = pstamp_r[s];
      if (in_data.side == SIDE_W'(s)) begin
        unique case (in_data.op)
          OP_PULSE: begin
            snap.side[s].prev_count = cnt_r[s];
            snap.side[s].prev_stamp = stamp_r[s];
            snap.side[s].count      = cnt_r[s] + CNT_W'(1);
            snap.side[s].stamp      = in_data.now_us;
          end
          OP_CLEAR: begin
            snap.side[s].count = '0;
            snap.side[s].stamp = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSIDE; s++) begin
        cnt_r[s]    <= '0;
        pcnt_r[s]   <= '0;
        stamp_r[s]  <= '0;
        pstamp_r[s] <= '0;
      end
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      job_cnt_r <= '0;
    end else begin
      if (accept) begin
        for (int s = 0; s < NSIDE; s++) begin
          cnt_r[s]    <= snap.side[s].count;
          pcnt_r[s]   <= snap.side[s].prev_count;
          stamp_r[s]  <= snap.side[s].stamp;
          pstamp_r[s] <= snap.side[s].prev_stamp;
        end
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (accept && !pop_ok) begin
        job_cnt_r <= job_cnt_r + QCNT_W'(1);
      end else if (!accept && pop_ok) begin
        job_cnt_r <= job_cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_mem_r[wr_ptr_r] <= snap;
    end
  end

  a_job_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_cnt_r <= QCNT_W'(QDEPTH))
    else $error("front: job queue count beyond depth");

  a_pulse_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_PULSE) |=>
      (cnt_r[$past(in_data.side)] == CNT_W'($past(cnt_r[in_data.side]) + CNT_W'(1))))
    else $error("front: pulse did not advance the count");

  a_clear_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_CLEAR) |=>
      (stamp_r[$past(in_data.side)] == '0 && cnt_r[$past(in_data.side)] == '0))
    else $error("front: clear left count or stamp set");

endmodule

// ===== rtl/weo_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry measurement back end
// Turns a state snapshot into distances and speeds for both sides, one side
// after the other through a shared multiplier path and a bit-serial divider,
// and queues the result item.
// ----------------------------------------------------------------------------
module weo_back (
  input  logic               clk,
  input  logic               rst_n,
  input  weo_pkg::cfg_t      cfg,
  input  logic               job_avail,
  output logic               job_pop,
  input  weo_pkg::job_t      job_head,
  output logic               empty,
  input  logic               pop,
  output weo_pkg::out_item_t out_data
);
  import weo_pkg::*;

  back_state_t state_r, state_nxt;
  back_ctrl_t  ctrl;

  job_t                  job_r;
  logic [SIDE_W-1:0]     side_r;
  logic [CNT_W+DPP_W-1:0] prod_r;
  logic [KDPP_W-1:0]     kdpp_r;
  logic [CNT_W-1:0]      cdiff_r;
  logic [TIME_W-1:0]     sdiff_r;
  logic                  ok_r;
  logic [LO_W+CNT_W-1:0] plo_r;
  logic [HI_W+CNT_W-1:0] phi_r;
  logic [NUM_W-1:0]      num_r;
  logic [TIME_W-1:0]     rem_r;
  logic [SPD_W-1:0]      qn_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [DIST_W-1:0]     dist_r [NSIDE];
  logic [SPD_W-1:0]      spd_r [NSIDE];

  out_item_t         res_mem_r [QDEPTH];
  logic [QPTR_W-1:0] res_wr_r, res_rd_r;
  logic [QCNT_W-1:0] res_cnt_r;

  side_snap_t        snap;
  logic [TIME_W-1:0] age;
  logic              ovf;
  logic              div_last;
  logic [TIME_W:0]   rem_sh;
  logic              rem_ge;
  logic              res_full;
  logic              res_pop;
  out_item_t         res;

  assign snap     = job_r.side[side_r];
  assign age      = job_r.now_us - snap.stamp;
  assign ovf      = (num_r[NUM_W-1:SPD_W] >= (NUM_W-SPD_W)'(sdiff_r));
  assign div_last = (div_cnt_r == DIV_CNT_W'(SPD_W - 1));
  assign rem_sh   = {rem_r, qn_r[SPD_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, sdiff_r});
  assign res_full = (res_cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (res_cnt_r == '0);
  assign res_pop  = pop && !empty;
  assign out_data = res_mem_r[res_rd_r];

  always_comb begin
    res.dist_left     = dist_r[0];
    res.dist_right    = dist_r[1];
    res.mean_distance = DIST_W'(({1'b0, dist_r[0]} + {1'b0, dist_r[1]}) >> 1);
    res.speed_left    = spd_r[0];
    res.speed_right   = spd_r[1];
    res.mean_speed    = SPD_W'(({1'b0, spd_r[0]} + {1'b0, spd_r[1]}) >> 1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (job_avail) state_nxt = B_MUL0;
      B_MUL0: state_nxt = B_MUL1;
      B_MUL1: state_nxt = B_MUL2;
      B_MUL2: state_nxt = B_NUM;
      B_NUM:  state_nxt = B_CHK;
      B_CHK: begin
        if (!ok_r || ovf) begin
          state_nxt = (side_r == SIDE_W'(NSIDE - 1)) ? B_OUT : B_MUL0;
        end else begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (div_last) begin
          state_nxt = (side_r == SIDE_W'(NSIDE - 1)) ? B_OUT : B_MUL0;
        end
      end
      B_OUT: if (!res_full) state_nxt = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      B_IDLE: ctrl.job_pop = job_avail;
      B_CHK:  ctrl.side_done = !ok_r || ovf;
      B_DIV:  ctrl.side_done = div_last;
      B_OUT:  ctrl.res_push = !res_full;
      default: begin
      end
    endcase
  end

  assign job_pop = ctrl.job_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      side_r    <= '0;
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.job_pop) begin
        side_r <= '0;
      end else if (ctrl.side_done) begin
        side_r <= side_r + SIDE_W'(1);
      end
      if (ctrl.res_push) begin
        res_wr_r <= res_wr_r + QPTR_W'(1);
      end
      if (res_pop) begin
        res_rd_r <= res_rd_r + QPTR_W'(1);
      end
      if (ctrl.res_push && !res_pop) begin
        res_cnt_r <= res_cnt_r + QCNT_W'(1);
      end else if (!ctrl.res_push && res_pop) begin
        res_cnt_r <= res_cnt_r - QCNT_W'(1);
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (job_avail) job_r <= job_head;
      end
      B_MUL0: begin
        prod_r  <= (CNT_W+DPP_W)'(snap.count) * (CNT_W+DPP_W)'(cfg.dist_per_pulse);
        kdpp_r  <= KDPP_W'(cfg.dist_per_pulse) * KDPP_W'(US_PER_S);
        cdiff_r <= snap.count - snap.prev_count;
        sdiff_r <= snap.stamp - snap.prev_stamp;
        ok_r    <= (snap.stamp > snap.prev_stamp) &&
                   (snap.count != snap.prev_count) &&
                   (age < TIME_W'(cfg.stale_limit_us));
      end
      B_MUL1: begin
        dist_r[side_r] <= (|prod_r[CNT_W+DPP_W-1:DIST_W]) ? '1 : prod_r[DIST_W-1:0];
        plo_r          <= (LO_W+CNT_W)'(kdpp_r[LO_W-1:0]) * (LO_W+CNT_W)'(cdiff_r);
      end
      B_MUL2: begin
        phi_r <= (HI_W+CNT_W)'(kdpp_r[KDPP_W-1:LO_W]) * (HI_W+CNT_W)'(cdiff_r);
      end
      B_NUM: begin
        num_r <= (NUM_W'(phi_r) << LO_W) + NUM_W'(plo_r);
      end
      B_CHK: begin
        if (!ok_r) begin
          spd_r[side_r] <= '0;
        end else if (ovf) begin
          spd_r[side_r] <= '1;
        end else begin
          // The quotient fits in SPD_W bits, so the upper numerator bits
          // already form a remainder below the divisor.
          rem_r     <= num_r[SPD_W +: TIME_W];
          qn_r      <= num_r[SPD_W-1:0];
          div_cnt_r <= '0;
        end
      end
      B_DIV: begin
        rem_r     <= rem_ge ? TIME_W'(rem_sh - {1'b0, sdiff_r}) : rem_sh[TIME_W-1:0];
        qn_r      <= {qn_r[SPD_W-2:0], rem_ge};
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          spd_r[side_r] <= {qn_r[SPD_W-2:0], rem_ge};
        end
      end
      B_OUT: begin
        if (!res_full) res_mem_r[res_wr_r] <= res;
      end
    endcase
  end

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (rem_r < sdiff_r))
    else $error("back: divider remainder not below divisor");

  a_div_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (ok_r && sdiff_r != '0))
    else $error("back: division started without a valid period");

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= QCNT_W'(QDEPTH))
    else $error("back: result queue count beyond depth");

endmodule

// ===== rtl/wheel_encoder_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel encoder odometry
// Two-wheel odometry: pulse counts, distances and pulse-period speeds.
// ----------------------------------------------------------------------------
// Each accepted item (any operation on one side) yields one result item with
// both distances and their mean in unsigned Q32.16 and both speeds and their
// mean in unsigned Q16.16. Items enter a two-deep queue as soon as their
// operation is applied, so the input side keeps taking items while earlier
// ones are measured. The measurement handles one item at a time, each side
// through multiply and check steps and, for a valid speed, the bit-serial
// divider. Results wait in a two-deep output queue. Configuration is to be
// written only while no item is in flight; the block does not enforce this.
module wheel_encoder_odometry (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  weo_pkg::in_item_t                    in_data,
  output logic                                 empty,
  input  logic                                 pop,
  output weo_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [weo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [weo_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import weo_pkg::*;

  cfg_t cfg_r;
  logic job_avail;
  logic job_pop;
  job_t job_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dist_per_pulse <= DPP_RESET;
      cfg_r.stale_limit_us <= STALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DPP:   cfg_r.dist_per_pulse <= cfg_data[DPP_W-1:0];
        CFG_STALE: cfg_r.stale_limit_us <= cfg_data[STALE_W-1:0];
      endcase
    end
  end

  weo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .job_avail (job_avail),
    .job_pop   (job_pop),
    .job_head  (job_head)
  );

  weo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_avail (job_avail),
    .job_pop   (job_pop),
    .job_head  (job_head),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_wheel_encoder_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel encoder odometry testbench
// Drives pulse, sample and clear items for both wheels through the queue
// ports and checks every result against a local odometry predictor. Runs
// several register settings, the extremes among them, under changing
// sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_wheel_encoder_odometry;
  import weo_pkg::*;

  localparam logic [OP_W-1:0]   OP_SPARE  = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam int                DRAIN_CYC = 80;

  // Odometry predictor and the readings it still expects from the block.
  class odometry_tracker;
    logic [DPP_W-1:0]   dpp;
    logic [STALE_W-1:0] stale;
    logic [CNT_W-1:0]   count      [NSIDE];
    logic [CNT_W-1:0]   prev_count [NSIDE];
    logic [TIME_W-1:0]  stamp      [NSIDE];
    logic [TIME_W-1:0]  prev_stamp [NSIDE];
    out_item_t          pending_readings [$];
    int unsigned        errors;
    int unsigned        items_seen;
    int unsigned        readings_seen;
    int unsigned        moving_seen;

    function new();
      dpp   = DPP_RESET;
      stale = STALE_RESET;
      for (int s = 0; s < NSIDE; s++) begin
        count[s]      = '0;
        prev_count[s] = '0;
        stamp[s]      = '0;
        prev_stamp[s] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DPP:   dpp = data[DPP_W-1:0];
        CFG_STALE: stale = data[STALE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DIST_W-1:0] distance_of(int s);
      logic [63:0] prod;
      prod = 64'(count[s]) * 64'(dpp);
      if (prod > 64'(TIME_MAX)) return '1;
      return prod[DIST_W-1:0];
    endfunction

    function logic [SPD_W-1:0] speed_of(int s, logic [TIME_W-1:0] now);
      logic [CNT_W-1:0]  diff;
      logic [TIME_W-1:0] age;
      logic [127:0]      num;
      logic [127:0]      quo;
      diff = count[s] - prev_count[s];
      age  = now - stamp[s];
      if (stamp[s] <= prev_stamp[s] || diff == 0 || age >= TIME_W'(stale)) return '0;
      num = 128'(dpp) * 128'(1000000) * 128'(diff);
      quo = num / 128'(stamp[s] - prev_stamp[s]);
      if (quo > 128'(32'hFFFF_FFFF)) return '1;
      return quo[SPD_W-1:0];
    endfunction

    function void take_item(in_item_t it);
      int        s;
      out_item_t r;
      logic [DIST_W:0] dsum;
      logic [SPD_W:0]  ssum;
      s = int'(it.side);
      case (it.op)
        OP_PULSE: begin
          prev_count[s] = count[s];
          prev_stamp[s] = stamp[s];
          count[s]      = count[s] + CNT_W'(1);
          stamp[s]      = it.now_us;
        end
        OP_CLEAR: begin
          count[s] = '0;
          stamp[s] = '0;
        end
        default: ;
      endcase
      r.dist_left      = distance_of(0);
      r.dist_right     = distance_of(1);
      dsum             = {1'b0, r.dist_left} + {1'b0, r.dist_right};
      r.mean_distance  = dsum[DIST_W:1];
      r.speed_left     = speed_of(0, it.now_us);
      r.speed_right    = speed_of(1, it.now_us);
      ssum             = {1'b0, r.speed_left} + {1'b0, r.speed_right};
      r.mean_speed     = ssum[SPD_W:1];
      if (ssum != 0) moving_seen++;
      pending_readings.push_back(r);
      items_seen++;
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      check_field("dist_left",     want.dist_left,     got.dist_left);
      check_field("dist_right",    want.dist_right,    got.dist_right);
      check_field("mean_distance", want.mean_distance, got.mean_distance);
      check_field("speed_left",    want.speed_left,    got.speed_left);
      check_field("speed_right",   want.speed_right,   got.speed_right);
      check_field("mean_speed",    want.mean_speed,    got.mean_speed);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  in_item_t              in_data;
  logic                  empty;
  logic                  pop;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  odometry_tracker   tracker;
  int unsigned       send_idle_pct;
  int unsigned       stall_pct;
  int unsigned       hold_left;
  int unsigned       settings_run;
  logic [TIME_W-1:0] clock_us;

  wheel_encoder_odometry u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_wheel_encoder_odometry NOT OK");
    $finish;
  end

  // Receiver: pops at random, and holds off entirely while hold_left runs down.
  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
      @(posedge clk);
      if (pop && !empty) tracker.match_result(out_data);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with push still high, so a following item can go out back to back.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.take_item(it);
    @(negedge clk);
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [SIDE_W-1:0] side,
                         logic [TIME_W-1:0] now);
    in_item_t it;
    it.op     = op;
    it.side   = side;
    it.now_us = now;
    send_item(it);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (tracker.pending_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Mostly a steadily advancing clock with pulses on it, so that speeds
  // come out valid; the rest is random times and operations.
  function automatic in_item_t make_item();
    in_item_t    it;
    int unsigned r;
    it.side = 1'($urandom);
    if ($urandom_range(99) < 78) begin
      r = $urandom_range(99);
      if (r < 65)      it.op = OP_PULSE;
      else if (r < 87) it.op = OP_SAMPLE;
      else if (r < 93) it.op = OP_CLEAR;
      else             it.op = OP_SPARE;
      r = $urandom_range(99);
      if (r < 15)      clock_us = clock_us + TIME_W'($urandom_range(0, 3));
      else if (r < 80) clock_us = clock_us + TIME_W'($urandom_range(4, 3000));
      else if (r < 95) clock_us = clock_us + TIME_W'($urandom_range(3000, 2000000));
      else             clock_us = clock_us + {16'($urandom), 32'($urandom)};
      it.now_us = clock_us;
    end else begin
      it.op = 2'($urandom_range(3));
      if ($urandom_range(1) == 0) it.now_us = {16'($urandom), 32'($urandom)};
      else                        it.now_us = clock_us - TIME_W'($urandom_range(0, 5000));
    end
    return it;
  endfunction

  task automatic run_phase(bit write_cfg, logic [DPP_W-1:0] dpp, logic [STALE_W-1:0] stale,
                           int unsigned sidle, int unsigned rstall, int n,
                           bit long_hold, bit mid_pause);
    if (write_cfg) begin
      write_reg(CFG_DPP, dpp);
      write_reg(CFG_STALE, {8'($urandom), stale});
    end
    send_idle_pct = sidle;
    stall_pct     = rstall;
    if ($urandom_range(1) == 0) clock_us = TIME_MAX - TIME_W'($urandom_range(0, 50000));
    else                        clock_us = 48'($urandom_range(0, 100000));
    for (int i = 0; i < n; i++) begin
      // The receiver stops long enough for the block to fill and stall input.
      if (long_hold && i == n / 3) hold_left = 400;
      if (mid_pause && i == n / 2) wait_drained();
      send_item(make_item());
    end
    wait_drained();
    settings_run++;
  endtask

  initial begin
    tracker       = new();
    rst_n         = 1'b0;
    push          = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    settings_run  = 0;
    clock_us      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset register values.
    send_op(OP_SAMPLE, 1'b0, '0);
    send_op(OP_PULSE,  1'b0, 48'd100);
    send_op(OP_PULSE,  1'b0, 48'd200);
    send_op(OP_PULSE,  1'b1, 48'd250);
    // A one microsecond period saturates the speed.
    send_op(OP_PULSE,  1'b1, 48'd251);
    send_op(OP_SPARE,  1'b1, 48'd300);
    // Left is exactly at the stale limit here, right just below it.
    send_op(OP_SAMPLE, 1'b0, 48'd1000200);
    send_op(OP_PULSE,  1'b0, 48'd1000300);
    send_op(OP_PULSE,  1'b0, 48'd1000300);
    send_op(OP_CLEAR,  1'b0, 48'd1000400);
    send_op(OP_SAMPLE, 1'b0, 48'd1000500);
    send_op(OP_PULSE,  1'b0, 48'd1000600);
    send_op(OP_PULSE,  1'b1, TIME_MAX);
    // The age wraps around the top of the time range and stays small.
    send_op(OP_SAMPLE, 1'b1, 48'd5);
    send_op(OP_PULSE,  1'b1, '0);
    send_op(OP_CLEAR,  1'b1, TIME_MAX);
    send_op(OP_CLEAR,  1'b1, 48'd10);
    send_op(OP_PULSE,  1'b1, 48'd20);
    send_op(OP_SPARE,  1'b0, 48'hAAAA_AAAA_AAAA);
    send_op(OP_SAMPLE, 1'b0, 48'h5555_5555_5555);
    wait_drained();

    run_phase(1'b0, DPP_RESET, STALE_RESET, 0, 0, 180, 1'b0, 1'b0);
    run_phase(1'b1, '0, '1, 72, 0, 180, 1'b0, 1'b0);
    run_phase(1'b1, '1, '1, 0, 72, 180, 1'b0, 1'b0);
    run_phase(1'b1, 32'd1, 24'd1, 12, 12, 180, 1'b0, 1'b0);
    run_phase(1'b1, 32'($urandom), 24'($urandom_range(1, 24'hFFFFFF)), 0, 0, 220,
              1'b1, 1'b1);
    run_phase(1'b1, 32'd196608, '0, 12, 12, 120, 1'b0, 1'b0);
    run_phase(1'b1, 32'($urandom_range(1, 1 << 20)), 24'd5000, 72, 72, 200, 1'b0, 1'b0);
    run_phase(1'b1, DPP_RESET, STALE_RESET, 12, 12, 200, 1'b0, 1'b0);

    $display("Ran %0d items under %0d register settings,", tracker.items_seen,
             settings_run);
    $display("pulses, samples and clears on both wheels, with %0d results checked,",
             tracker.readings_seen);
    $display("%0d of them with a wheel in motion.", tracker.moving_seen);
    if (tracker.errors == 0) begin
      $display("tb_wheel_encoder_odometry OK");
    end else begin
      $display("tb_wheel_encoder_odometry NOT OK");
    end
    $finish;
  end

endmodule
